FILE: hw/rtl/upsample_gradient_block_sum_macros.svh
// Assertion helpers, sampled on clk and disabled while rst_n is low.
`ifndef UPSAMPLE_GRADIENT_BLOCK_SUM_MACROS_SVH
`define UPSAMPLE_GRADIENT_BLOCK_SUM_MACROS_SVH

`define UGBS_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

`define UGBS_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define UGBS_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/ugbs_pkg.sv
package ugbs_pkg;

    localparam int SUM_BITS       = 25;
    localparam int COUNT_BITS     = 10;
    localparam int DIM_BITS       = 11;
    localparam int CFG_DATA_BITS  = 11;
    localparam int CFG_INDEX_BITS = 3;
    localparam int MAX_COUNT      = 1024;
    localparam int OUT_DEPTH      = 4;
    localparam int OUT_PTR_BITS   = 2;
    localparam int OUT_CNT_BITS   = 3;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_KERNEL_CHAN  = 3'd0,
        REG_KERNEL_ROWS  = 3'd1,
        REG_KERNEL_COLS  = 3'd2,
        REG_OUT_WIDTH    = 3'd3,
        REG_OUT_HEIGHT   = 3'd4,
        REG_OUT_CHANNELS = 3'd5,
        REG_BATCH_COUNT  = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [3:0]  kernel_chan;
        logic [3:0]  kernel_rows;
        logic [3:0]  kernel_cols;
        logic [6:0]  out_width;
        logic [6:0]  out_height;
        logic [10:0] out_channels;
        logic [10:0] batch_count;
    } cfg_t;

    // position flags of one word within its block and the tensor
    typedef struct packed {
        logic first;
        logic last;
        logic tend;
    } tag_t;

    typedef struct packed {
        logic busy;
        logic push;
        logic tend;
    } acc_stat_t;

    // 0 acts as 1, anything above hi acts as hi
    function automatic logic [DIM_BITS-1:0] clamp_dim(
        input logic [DIM_BITS-1:0] v,
        input logic [DIM_BITS-1:0] hi
    );
        logic [DIM_BITS-1:0] r;
        begin
            if (v == '0)
                r = DIM_BITS'(1);
            else if (v > hi)
                r = hi;
            else
                r = v;
            return r;
        end
    endfunction

endpackage

FILE: hw/rtl/ugbs_addr_gen.sv
module ugbs_addr_gen #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64,
    parameter int MAX_KERNEL = 8,
    parameter int AW         = 12
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            restart,
    input  logic            advance,
    input  ugbs_pkg::cfg_t  cfg,
    output logic [AW-1:0]   addr,
    output ugbs_pkg::tag_t  tag
);
    import ugbs_pkg::*;

    localparam int KB = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int CB = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RB = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    logic [DIM_BITS-1:0] kc_last, kr_last, kw_last, ow_last, oh_last, oc_last, bc_last;

    logic [KB-1:0]         ocol_reg, ocol_next;
    logic [KB-1:0]         orow_reg, orow_next;
    logic [KB-1:0]         cib_reg, cib_next;
    logic [CB-1:0]         ccol_reg, ccol_next;
    logic [RB-1:0]         crow_reg, crow_next;
    logic [AW-1:0]         row_base_reg, row_base_next;
    logic [COUNT_BITS-1:0] chan_reg, chan_next;
    logic [COUNT_BITS-1:0] image_reg, image_next;

    logic ocol_end, ccol_end, orow_end, crow_end, cib_end, chan_end, image_end;

    assign kc_last = clamp_dim(DIM_BITS'(cfg.kernel_chan), DIM_BITS'(MAX_KERNEL)) - DIM_BITS'(1);
    assign kr_last = clamp_dim(DIM_BITS'(cfg.kernel_rows), DIM_BITS'(MAX_KERNEL)) - DIM_BITS'(1);
    assign kw_last = clamp_dim(DIM_BITS'(cfg.kernel_cols), DIM_BITS'(MAX_KERNEL)) - DIM_BITS'(1);
    assign ow_last = clamp_dim(DIM_BITS'(cfg.out_width), DIM_BITS'(MAX_WIDTH)) - DIM_BITS'(1);
    assign oh_last = clamp_dim(DIM_BITS'(cfg.out_height), DIM_BITS'(MAX_HEIGHT)) - DIM_BITS'(1);
    assign oc_last = clamp_dim(cfg.out_channels, DIM_BITS'(MAX_COUNT)) - DIM_BITS'(1);
    assign bc_last = clamp_dim(cfg.batch_count, DIM_BITS'(MAX_COUNT)) - DIM_BITS'(1);

    assign ocol_end  = (DIM_BITS'(ocol_reg) == kw_last);
    assign ccol_end  = (DIM_BITS'(ccol_reg) == ow_last);
    assign orow_end  = (DIM_BITS'(orow_reg) == kr_last);
    assign crow_end  = (DIM_BITS'(crow_reg) == oh_last);
    assign cib_end   = (DIM_BITS'(cib_reg) == kc_last);
    assign chan_end  = (DIM_BITS'(chan_reg) == oc_last);
    assign image_end = (DIM_BITS'(image_reg) == bc_last);

    assign addr = row_base_reg + AW'(ccol_reg);

    assign tag.first = (cib_reg == '0) && (orow_reg == '0) && (ocol_reg == '0);
    assign tag.last  = cib_end && orow_end && ocol_end;
    assign tag.tend  = tag.last && image_end && chan_end && crow_end && ccol_end;

    always_comb
    begin
        ocol_next     = ocol_reg;
        ccol_next     = ccol_reg;
        orow_next     = orow_reg;
        crow_next     = crow_reg;
        row_base_next = row_base_reg;
        cib_next      = cib_reg;
        chan_next     = chan_reg;
        image_next    = image_reg;
        if (restart)
        begin
            ocol_next     = '0;
            ccol_next     = '0;
            orow_next     = '0;
            crow_next     = '0;
            row_base_next = '0;
            cib_next      = '0;
            chan_next     = '0;
            image_next    = '0;
        end
        else if (advance)
        begin
            if (!ocol_end)
                ocol_next = ocol_reg + KB'(1);
            else
            begin
                ocol_next = '0;
                if (!ccol_end)
                    ccol_next = ccol_reg + CB'(1);
                else
                begin
                    ccol_next = '0;
                    // end of an upsampled row
                    if (!orow_end)
                        orow_next = orow_reg + KB'(1);
                    else
                    begin
                        orow_next = '0;
                        if (!crow_end)
                        begin
                            crow_next     = crow_reg + RB'(1);
                            row_base_next = row_base_reg + AW'(MAX_WIDTH);
                        end
                        else
                        begin
                            crow_next     = '0;
                            row_base_next = '0;
                            // end of an upsampled plane
                            if (!cib_end)
                                cib_next = cib_reg + KB'(1);
                            else
                            begin
                                cib_next = '0;
                                if (!chan_end)
                                    chan_next = chan_reg + COUNT_BITS'(1);
                                else
                                begin
                                    chan_next = '0;
                                    if (!image_end)
                                        image_next = image_reg + COUNT_BITS'(1);
                                    else
                                        image_next = '0;
                                end
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ocol_reg     <= '0;
            ccol_reg     <= '0;
            orow_reg     <= '0;
            crow_reg     <= '0;
            row_base_reg <= '0;
            cib_reg      <= '0;
            chan_reg     <= '0;
            image_reg    <= '0;
        end
        else
        begin
            ocol_reg     <= ocol_next;
            ccol_reg     <= ccol_next;
            orow_reg     <= orow_next;
            crow_reg     <= crow_next;
            row_base_reg <= row_base_next;
            cib_reg      <= cib_next;
            chan_reg     <= chan_next;
            image_reg    <= image_next;
        end
    end

endmodule

FILE: hw/rtl/ugbs_accum.sv
module ugbs_accum #(
    parameter int MAX_WIDTH   = 64,
    parameter int MAX_HEIGHT  = 64,
    parameter int SAMPLE_BITS = 16,
    parameter int AW          = 12
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                rd_en,
    input  logic [AW-1:0]                       addr,
    input  ugbs_pkg::tag_t                      tag,
    input  logic signed [SAMPLE_BITS-1:0]       sample,
    output ugbs_pkg::acc_stat_t                 stat,
    output logic signed [ugbs_pkg::SUM_BITS-1:0] sum
);
    import ugbs_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int WIDE  = 33;

    logic [SUM_BITS-1:0] mem [DEPTH];

    logic                          s1_valid_reg;
    logic [AW-1:0]                 s1_addr_reg;
    tag_t                          s1_tag_reg;
    logic signed [SAMPLE_BITS-1:0] s1_sample_reg;
    logic [SUM_BITS-1:0]           rd_data_reg;

    logic                fwd_valid_reg;
    logic [AW-1:0]       fwd_addr_reg;
    logic [SUM_BITS-1:0] fwd_data_reg;

    logic [WIDE-1:0]     sample_wide;
    logic [SUM_BITS-1:0] acc;

    // the write of the previous word lands in the same edge as this word's read
    always_comb
    begin
        if (s1_tag_reg.first)
            acc = '0;
        else if (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg))
            acc = fwd_data_reg;
        else
            acc = rd_data_reg;
    end

    assign sample_wide = WIDE'(s1_sample_reg);
    assign sum         = acc + SUM_BITS'(sample_wide);

    assign stat.busy = s1_valid_reg;
    assign stat.push = s1_valid_reg && s1_tag_reg.last;
    assign stat.tend = s1_tag_reg.tend;

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[addr];
        if (s1_valid_reg)
            mem[s1_addr_reg] <= sum;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            s1_addr_reg   <= addr;
            s1_tag_reg    <= tag;
            s1_sample_reg <= sample;
        end
        fwd_addr_reg <= s1_addr_reg;
        fwd_data_reg <= sum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= rd_en;
            fwd_valid_reg <= s1_valid_reg;
        end
    end

endmodule

FILE: hw/rtl/ugbs_out_fifo.sv
module ugbs_out_fifo (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    input  logic [ugbs_pkg::SUM_BITS-1:0]        push_sum,
    input  logic                                 push_tend,
    input  logic                                 pop,
    output logic                                 head_valid,
    output logic [ugbs_pkg::SUM_BITS-1:0]        head_sum,
    output logic                                 head_tend,
    output logic [ugbs_pkg::OUT_CNT_BITS-1:0]    count
);
    import ugbs_pkg::*;

    logic [SUM_BITS:0] entry [OUT_DEPTH];

    logic [OUT_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OUT_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OUT_CNT_BITS-1:0] count_reg, count_next;
    logic                    do_pop;

    assign head_valid = (count_reg != '0);
    assign do_pop     = pop && head_valid;
    assign head_sum   = entry[rd_ptr_reg][SUM_BITS-1:0];
    assign head_tend  = entry[rd_ptr_reg][SUM_BITS];
    assign count      = count_reg;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + OUT_PTR_BITS'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + OUT_PTR_BITS'(1) : rd_ptr_reg;
        count_next  = count_reg;
        case ({push, do_pop})
            2'b10:   count_next = count_reg + OUT_CNT_BITS'(1);
            2'b01:   count_next = count_reg - OUT_CNT_BITS'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry[wr_ptr_reg] <= {push_tend, push_sum};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: hw/rtl/upsample_gradient_block_sum.sv
// A block's sum is registered into the output queue from the accumulate stage.
// Throughput: one word per cycle unless stalled; one accumulator read-modify-write
// per word, the write of a word forwarded to the read of the word right behind it.
// A four-entry output queue absorbs downstream stalls; input stalls when it may fill.
// Reset: counters and handshake cleared, all registers back to 1; the accumulator
// memory is not cleared, since the first word of every block overwrites its entry.
`include "upsample_gradient_block_sum_macros.svh"

module upsample_gradient_block_sum #(
    parameter int MAX_WIDTH   = 64,
    parameter int MAX_HEIGHT  = 64,
    parameter int MAX_KERNEL  = 8,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [ugbs_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [ugbs_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [SAMPLE_BITS-1:0]          sample,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [ugbs_pkg::SUM_BITS-1:0]   block_sum,
    output logic                                   tensor_end
);
    import ugbs_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    cfg_t cfg_reg, cfg_next;
    logic restart;

    logic                    accept;
    logic [AW-1:0]           addr;
    tag_t                    tag;
    acc_stat_t               stat;
    logic [SUM_BITS-1:0]     sum;
    logic [OUT_CNT_BITS-1:0] count;

    always_comb
    begin
        cfg_next = cfg_reg;
        restart  = cfg_we;
        case (cfg_reg_t'(cfg_index))
            REG_KERNEL_CHAN:  cfg_next.kernel_chan  = cfg_data[3:0];
            REG_KERNEL_ROWS:  cfg_next.kernel_rows  = cfg_data[3:0];
            REG_KERNEL_COLS:  cfg_next.kernel_cols  = cfg_data[3:0];
            REG_OUT_WIDTH:    cfg_next.out_width    = cfg_data[6:0];
            REG_OUT_HEIGHT:   cfg_next.out_height   = cfg_data[6:0];
            REG_OUT_CHANNELS: cfg_next.out_channels = cfg_data;
            REG_BATCH_COUNT:  cfg_next.batch_count  = cfg_data;
            default:          restart = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kernel_chan  <= 4'd1;
            cfg_reg.kernel_rows  <= 4'd1;
            cfg_reg.kernel_cols  <= 4'd1;
            cfg_reg.out_width    <= 7'd1;
            cfg_reg.out_height   <= 7'd1;
            cfg_reg.out_channels <= 11'd1;
            cfg_reg.batch_count  <= 11'd1;
        end
        else if (cfg_we)
        begin
            cfg_reg <= cfg_next;
        end
    end

    // room for the word in flight plus the one taken now
    assign in_stall = ((OUT_CNT_BITS'(count) + OUT_CNT_BITS'(stat.push))
                       >= OUT_CNT_BITS'(OUT_DEPTH));
    assign accept   = in_valid && !in_stall;

    ugbs_addr_gen #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_KERNEL (MAX_KERNEL),
        .AW         (AW)
    ) u_addr_gen (
        .clk     (clk),
        .rst_n   (rst_n),
        .restart (restart),
        .advance (accept),
        .cfg     (cfg_reg),
        .addr    (addr),
        .tag     (tag)
    );

    ugbs_accum #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .SAMPLE_BITS (SAMPLE_BITS),
        .AW          (AW)
    ) u_accum (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_en  (accept),
        .addr   (addr),
        .tag    (tag),
        .sample (sample),
        .stat   (stat),
        .sum    (sum)
    );

    ugbs_out_fifo u_out_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (stat.push),
        .push_sum   (sum),
        .push_tend  (stat.tend),
        .pop        (!out_stall),
        .head_valid (out_valid),
        .head_sum   (block_sum),
        .head_tend  (tensor_end),
        .count      (count)
    );

    `UGBS_ALWAYS(a_fifo_bound, count <= OUT_CNT_BITS'(OUT_DEPTH), "output queue overfilled")
    `UGBS_IMPLIES(a_push_room, stat.push, count != OUT_CNT_BITS'(OUT_DEPTH), "push into full queue")
    `UGBS_NEXT(a_accept_busy, accept, stat.busy, "accepted word missing in accumulate stage")
    `UGBS_IMPLIES(a_tend_last, accept && tag.tend, tag.last, "tensor end off a block end")

endmodule

FILE: sim/upsample_gradient_block_sum_tb.sv
`timescale 1ns / 100ps

module upsample_gradient_block_sum_tb;
    import ugbs_pkg::*;

    localparam int MAX_DIM      = 64;
    localparam int MAX_KERNEL   = 8;
    localparam int ACC_ENTRIES  = MAX_DIM * MAX_DIM;
    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 4;

    typedef struct packed {
        logic signed [SUM_BITS-1:0] total;
        logic                       tail;
    } block_total_t;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       cfg_we    = 1'b0;
    cfg_reg_t                   cfg_index = REG_KERNEL_CHAN;
    logic [CFG_DATA_BITS-1:0]   cfg_data  = '0;
    logic                       in_valid  = 1'b0;
    logic                       in_stall;
    logic signed [15:0]         sample    = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic signed [SUM_BITS-1:0] block_sum;
    logic                       tensor_end;

    int unsigned send_idle_pct  = 33;
    int unsigned recv_stall_pct = 88;
    int unsigned error_count    = 0;
    int unsigned quiet_cycles   = 0;

    // shadow of the block: registers, traversal position, accumulator plane
    cfg_t                       shadow_cfg;
    int unsigned                col_at   = 0;
    int unsigned                row_at   = 0;
    int unsigned                chan_sub = 0;
    int unsigned                chan_at  = 0;
    int unsigned                image_at = 0;
    logic signed [SUM_BITS-1:0] acc_shadow [ACC_ENTRIES];
    block_total_t               expected_totals [$];

    upsample_gradient_block_sum uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample     (sample),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .block_sum  (block_sum),
        .tensor_end (tensor_end)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic int unsigned clamp_to(input int unsigned v, input int unsigned hi);
        if (v < 1)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic longint unsigned words_per_tensor();
        longint unsigned n;
        n = clamp_to(shadow_cfg.kernel_chan, MAX_KERNEL);
        n = n * clamp_to(shadow_cfg.kernel_rows, MAX_KERNEL);
        n = n * clamp_to(shadow_cfg.kernel_cols, MAX_KERNEL);
        n = n * clamp_to(shadow_cfg.out_width, MAX_DIM);
        n = n * clamp_to(shadow_cfg.out_height, MAX_DIM);
        n = n * clamp_to(shadow_cfg.out_channels, MAX_COUNT);
        n = n * clamp_to(shadow_cfg.batch_count, MAX_COUNT);
        return n;
    endfunction

    function automatic void accumulate_word(input logic signed [15:0] s);
        int unsigned                kc, kr, kw, ow, oh, oc, bc, wy, hy, idx;
        logic                       first_word, last_word, tail_word;
        logic signed [SUM_BITS-1:0] acc, sum_now;
        kc = clamp_to(shadow_cfg.kernel_chan, MAX_KERNEL);
        kr = clamp_to(shadow_cfg.kernel_rows, MAX_KERNEL);
        kw = clamp_to(shadow_cfg.kernel_cols, MAX_KERNEL);
        ow = clamp_to(shadow_cfg.out_width, MAX_DIM);
        oh = clamp_to(shadow_cfg.out_height, MAX_DIM);
        oc = clamp_to(shadow_cfg.out_channels, MAX_COUNT);
        bc = clamp_to(shadow_cfg.batch_count, MAX_COUNT);
        wy = ow * kw;
        hy = oh * kr;
        idx = ((row_at / kr) * MAX_DIM + col_at / kw) % ACC_ENTRIES;
        first_word = (chan_sub == 0) && (row_at % kr == 0) && (col_at % kw == 0);
        last_word  = (chan_sub == kc - 1) && (row_at % kr == kr - 1) && (col_at % kw == kw - 1);
        tail_word  = last_word && (image_at == bc - 1) && (chan_at == oc - 1) &&
                     (row_at == hy - 1) && (col_at == wy - 1);
        acc = first_word ? '0 : acc_shadow[idx];
        sum_now = acc + s;
        acc_shadow[idx] = sum_now;

        col_at++;
        if (col_at >= wy)
        begin
            col_at = 0;
            row_at++;
            if (row_at >= hy)
            begin
                row_at = 0;
                chan_sub++;
                if (chan_sub >= kc)
                begin
                    chan_sub = 0;
                    chan_at++;
                    if (chan_at >= oc)
                    begin
                        chan_at = 0;
                        image_at++;
                        if (image_at >= bc)
                            image_at = 0;
                    end
                end
            end
        end

        if (last_word)
            expected_totals.push_back(block_total_t'{sum_now, tail_word});
    endfunction

    function automatic logic signed [15:0] random_sample();
        case ($urandom_range(7))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            default: return 16'($urandom);
        endcase
    endfunction

    // holds valid low until every pending sum is out and the pipe is empty
    task automatic wait_until_drained();
        in_valid <= 1'b0;
        while (expected_totals.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t which, input int unsigned value);
        cfg_we    <= 1'b1;
        cfg_index <= which;
        cfg_data  <= CFG_DATA_BITS'(value);
        case (which)
            REG_KERNEL_CHAN:  shadow_cfg.kernel_chan  = 4'(value);
            REG_KERNEL_ROWS:  shadow_cfg.kernel_rows  = 4'(value);
            REG_KERNEL_COLS:  shadow_cfg.kernel_cols  = 4'(value);
            REG_OUT_WIDTH:    shadow_cfg.out_width    = 7'(value);
            REG_OUT_HEIGHT:   shadow_cfg.out_height   = 7'(value);
            REG_OUT_CHANNELS: shadow_cfg.out_channels = 11'(value);
            REG_BATCH_COUNT:  shadow_cfg.batch_count  = 11'(value);
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic program_tensor(input int unsigned kc, input int unsigned kr,
                                  input int unsigned kw, input int unsigned ow,
                                  input int unsigned oh, input int unsigned oc,
                                  input int unsigned bc);
        wait_until_drained();
        write_reg(REG_KERNEL_CHAN, kc);
        write_reg(REG_KERNEL_ROWS, kr);
        write_reg(REG_KERNEL_COLS, kw);
        write_reg(REG_OUT_WIDTH, ow);
        write_reg(REG_OUT_HEIGHT, oh);
        write_reg(REG_OUT_CHANNELS, oc);
        write_reg(REG_BATCH_COUNT, bc);
        cfg_we <= 1'b0;
        // any write restarts the traversal, accumulator contents stay
        col_at   = 0;
        row_at   = 0;
        chan_sub = 0;
        chan_at  = 0;
        image_at = 0;
    endtask

    task automatic send_word(input logic signed [15:0] s);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= s;
        accumulate_word(s);
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // registers still at reset: every word is a one-element tensor
    task automatic test_reset_defaults();
        send_word(16'sh7fff);
        send_word(16'sh8000);
        send_word(random_sample());
    endtask

    // zero block sizes and dims act as 1, an oversize kernel acts as MAX_KERNEL
    task automatic test_clamped_registers();
        program_tensor(0, 1, 15, 0, 0, 0, 0);
        repeat (8) send_word(random_sample());
    endtask

    // abandon a block halfway; the rewrite must start a fresh tensor
    task automatic test_restart_mid_block();
        program_tensor(2, 1, 2, 2, 1, 1, 1);
        repeat (3) send_word(random_sample());
        program_tensor(2, 1, 2, 2, 1, 1, 1);
        repeat (8) send_word(random_sample());
    endtask

    // 8x8x8 blocks at full scale reach both ends of the sum range
    task automatic test_largest_blocks();
        program_tensor(8, 8, 8, 1, 1, 1, 2);
        repeat (512) send_word(16'sh7fff);
        repeat (512) send_word(16'sh8000);
    endtask

    task automatic test_random_tensors(input int unsigned word_budget);
        int unsigned     sent;
        int unsigned     n;
        longint unsigned full;
        sent = 0;
        while (sent < word_budget)
        begin
            case ($urandom_range(9))
                0: program_tensor(1, 1, 1, $urandom_range(1, 2),
                                  ($urandom_range(3) == 0) ? $urandom_range(65, 127)
                                                           : $urandom_range(32, 64),
                                  $urandom_range(1, 2), 1);
                1: program_tensor(1, 1, $urandom_range(1, 2),
                                  ($urandom_range(3) == 0) ? $urandom_range(65, 127)
                                                           : $urandom_range(32, 64),
                                  $urandom_range(1, 2), 1, 1);
                2: program_tensor($urandom_range(15), $urandom_range(15), $urandom_range(15),
                                  $urandom_range(127), $urandom_range(127),
                                  $urandom_range(2047), $urandom_range(2047));
                default: program_tensor($urandom_range(1, 3), $urandom_range(1, 2),
                                        $urandom_range(1, 3), $urandom_range(1, 3),
                                        $urandom_range(1, 2), $urandom_range(1, 2),
                                        $urandom_range(1, 2));
            endcase
            full = words_per_tensor();
            if (full > 400)
                n = 300;
            else if (full <= 200 && $urandom_range(1) == 1)
                n = 2 * int'(full);
            else
                n = int'(full);
            // occasionally cut the tensor short
            if ($urandom_range(9) == 0)
                n = $urandom_range(1, n);
            if (n > word_budget - sent)
                n = word_budget - sent;
            repeat (n) send_word(random_sample());
            sent += n;
        end
    endtask

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin : check_sums
        block_total_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_totals.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected word, block_sum %0d tensor_end %0b",
                         $time, block_sum, tensor_end);
            end
            else
            begin
                want = expected_totals.pop_front();
                if (block_sum !== want.total)
                begin
                    error_count++;
                    $display("%0t: block_sum expected %0d, actual %0d",
                             $time, $signed(want.total), block_sum);
                end
                if (tensor_end !== want.tail)
                begin
                    error_count++;
                    $display("%0t: tensor_end expected %0b, actual %0b",
                             $time, want.tail, tensor_end);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        shadow_cfg = '{4'd1, 4'd1, 4'd1, 7'd1, 7'd1, 11'd1, 11'd1};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_clamped_registers();
        test_restart_mid_block();
        test_largest_blocks();
        test_random_tensors(170);

        send_idle_pct  = 88;
        recv_stall_pct = 33;
        test_random_tensors(170);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random_tensors(170);

        wait_until_drained();
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
